@@ rtl/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants and tables for the great-circle distance block
// Fixed-point formats, CORDIC arctangent table and degree conversion tables.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    // Fraction bits of the degree inputs.
    localparam int ANGLE_FRAC_BITS = 16;
    // CORDIC iterations and integer square root steps.
    localparam int ITERS      = 30;
    localparam int SQRT_STEPS = 31;
    // Width of CORDIC datapath registers (Q2.30 with guard bits).
    localparam int CW = 34;

    // Degree magnitude width: covers the longitude difference.
    localparam int MAG_W = 26;
    // Division by 45 through a reciprocal: floor(mag * DIV45_MUL / 2^DIV45_SHIFT).
    localparam logic [26:0] DIV45_MUL   = 27'd95443718;
    localparam int          DIV45_SHIFT = 32;
    localparam int          QUOT_SHIFT  = 29 - ANGLE_FRAC_BITS;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic [31:0]          KM_SCALE    = 32'd2623417457;
    localparam logic [22:0]          HALF_CIRC   = 23'd5123862;

    typedef logic [31:0] t_atan_tab [ITERS];
    localparam t_atan_tab ATAN_TAB = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Binary-angle contribution of a remainder modulo 45 degree units.
    typedef logic [31:0] t_rem_tab [45];
    function automatic t_rem_tab rem_table();
        t_rem_tab t;
        for (int i = 0; i < 45; i++) begin
            t[i] = 32'((longint'(i) * (longint'(1) << (30 - ANGLE_FRAC_BITS)) + 45) / 90);
        end
        return t;
    endfunction
    localparam t_rem_tab REM_TAB = rem_table();

endpackage

`default_nettype wire

@@ rtl/great_circle_distance.sv @@
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// Three parallel 30-stage sine/cosine CORDIC pipelines are followed by the
// 31-stage square root and the 30-stage vectoring CORDIC.
// Reset (synchronous, active low) clears only the valid bits; items in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// great_circle_distance: spherical law of cosines distance, fully pipelined
// Converts both points to binary angles, takes sines and cosines, forms the
// cosine sum, takes its arccosine and scales to kilometres times 256.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic signed [23:0]  i_lat_a,
    input  wire logic signed [24:0]  i_lng_a,
    input  wire logic signed [23:0]  i_lat_b,
    input  wire logic signed [24:0]  i_lng_b,
    output logic                     o_valid,
    output logic [22:0]              o_distance_km
);

    localparam int CW = gcd_pkg::CW;
    localparam int MW = gcd_pkg::MAG_W;

    logic                   r_vin, r_vm1, r_vm2, r_vm3, r_vk1, r_vout;
    logic signed [MW-1:0]   r_lat_a, r_lat_b, r_dlng;
    logic                   w_acc;
    logic                   w_bva, w_bvb, w_bvd;
    logic [31:0]            w_ba, w_bb, w_bd;
    logic                   w_sva, w_svb, w_svd;
    logic signed [CW-1:0]   w_ca, w_sa, w_cb, w_sb, w_cd, w_sd;
    logic signed [2*CW-1:0] w_pab, w_sab, w_p1;
    logic signed [CW-1:0]   r_t1, r_p2, r_cd, r_p1, r_p2_d;
    logic signed [CW:0]     w_sum;
    logic signed [31:0]     r_sum;
    logic                   w_av;
    logic [31:0]            w_ang;
    logic [63:0]            r_kp;
    logic [63:0]            w_kr;
    logic [22:0]            r_dist;

    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vin  <= 1'b0;
            r_vm1  <= 1'b0;
            r_vm2  <= 1'b0;
            r_vm3  <= 1'b0;
            r_vk1  <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            r_vin  <= w_acc;
            r_vm1  <= w_sva;
            r_vm2  <= r_vm1;
            r_vm3  <= r_vm2;
            r_vk1  <= w_av;
            r_vout <= r_vk1;
        end
    end

    // Capture the item and form the exact longitude difference.
    always_ff @(posedge i_clk) begin
        r_lat_a <= MW'(i_lat_a);
        r_lat_b <= MW'(i_lat_b);
        r_dlng  <= MW'(i_lng_a) - MW'(i_lng_b);
    end

    gcd_bangle u_bangle_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vin), .i_deg(r_lat_a),
        .o_valid(w_bva), .o_angle(w_ba)
    );
    gcd_bangle u_bangle_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vin), .i_deg(r_lat_b),
        .o_valid(w_bvb), .o_angle(w_bb)
    );
    gcd_bangle u_bangle_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vin), .i_deg(r_dlng),
        .o_valid(w_bvd), .o_angle(w_bd)
    );

    gcd_sincos u_sincos_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_bva), .i_angle(w_ba),
        .o_valid(w_sva), .o_cos(w_ca), .o_sin(w_sa)
    );
    gcd_sincos u_sincos_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_bvb), .i_angle(w_bb),
        .o_valid(w_svb), .o_cos(w_cb), .o_sin(w_sb)
    );
    gcd_sincos u_sincos_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_bvd), .i_angle(w_bd),
        .o_valid(w_svd), .o_cos(w_cd), .o_sin(w_sd)
    );

    // Products, each rounded toward minus infinity after the Q30 shift.
    assign w_pab = w_cb * w_ca;
    assign w_sab = w_sb * w_sa;
    assign w_p1  = r_t1 * r_cd;
    assign w_sum = {r_p1[CW-1], r_p1} + {r_p2_d[CW-1], r_p2_d};

    always_ff @(posedge i_clk) begin
        r_t1   <= w_pab[CW+29:30];
        r_p2   <= w_sab[CW+29:30];
        r_cd   <= w_cd;
        r_p1   <= w_p1[CW+29:30];
        r_p2_d <= r_p2;
        // Clamp the cosine sum to [-1, 1].
        if (w_sum > (CW+1)'(gcd_pkg::ONE_Q30)) begin
            r_sum <= 32'sd1073741824;
        end else if (w_sum < -(CW+1)'(gcd_pkg::ONE_Q30)) begin
            r_sum <= -32'sd1073741824;
        end else begin
            r_sum <= w_sum[31:0];
        end
    end

    gcd_acos u_acos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vm3), .i_c(r_sum),
        .o_valid(w_av), .o_angle(w_ang)
    );

    // Scale the angle to kilometres times 256 and saturate.
    assign w_kr = (r_kp + (64'd1 << 39)) >> 40;

    always_ff @(posedge i_clk) begin
        r_kp <= 64'(w_ang) * 64'(gcd_pkg::KM_SCALE);
        if (w_kr > 64'(gcd_pkg::HALF_CIRC)) begin
            r_dist <= gcd_pkg::HALF_CIRC;
        end else begin
            r_dist <= w_kr[22:0];
        end
    end

    assign o_valid       = r_vout;
    assign o_distance_km = r_dist;

`ifndef SYNTHESIS
    // The three trig pipelines stay in lockstep.
    a_trig_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sva == w_svb) && (w_sva == w_svd))
        else $error("trig pipelines out of step");

    // The clamped cosine sum stays within [-1, 1].
    a_sum_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vm3 |-> ((r_sum <= 32'sd1073741824) && (r_sum >= -32'sd1073741824)))
        else $error("cosine sum outside [-1, 1]");

    // The arccosine never exceeds a half turn.
    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_av |-> (w_ang <= 32'h8000_0000))
        else $error("arccosine beyond half turn");

    // A delivered distance never exceeds the half circumference.
    a_dist_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distance_km <= gcd_pkg::HALF_CIRC))
        else $error("distance above half circumference");
`endif

endmodule

`default_nettype wire

@@ rtl/gcd_bangle.sv @@
// ----------------------------------------------------------------------------
// gcd_bangle: degrees to binary angle
// Four-stage pipeline: round(deg * 2^32 / 360), halves away from zero, mod 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_bangle (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [gcd_pkg::MAG_W-1:0]  i_deg,
    output logic                                   o_valid,
    output logic [31:0]                            o_angle
);

    logic [3:0]                  r_v;
    logic                        r_neg_a, r_neg_b, r_neg_c;
    logic [gcd_pkg::MAG_W-1:0]   r_mag_a, r_mag_b;
    logic [52:0]                 r_prod;
    logic [20:0]                 r_qm;
    logic [5:0]                  r_rm;
    logic [31:0]                 r_angle;
    logic [20:0]                 w_qm;
    logic [gcd_pkg::MAG_W-1:0]   w_rem;
    logic [31:0]                 w_r;

    // Valid bits follow the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Quotient and remainder of the magnitude by 45.
    assign w_qm  = r_prod[52:gcd_pkg::DIV45_SHIFT];
    assign w_rem = r_mag_b - (gcd_pkg::MAG_W'(w_qm) * gcd_pkg::MAG_W'(6'd45));
    // Quotient part scaled plus the remainder contribution from the table.
    assign w_r   = (32'(r_qm) << gcd_pkg::QUOT_SHIFT) + gcd_pkg::REM_TAB[r_rm];

    always_ff @(posedge i_clk) begin
        r_neg_a <= i_deg[gcd_pkg::MAG_W-1];
        r_mag_a <= i_deg[gcd_pkg::MAG_W-1] ? gcd_pkg::MAG_W'(-i_deg) : i_deg;
        r_prod  <= 53'(r_mag_a) * 53'(gcd_pkg::DIV45_MUL);
        r_mag_b <= r_mag_a;
        r_neg_b <= r_neg_a;
        r_qm    <= w_qm;
        r_rm    <= w_rem[5:0];
        r_neg_c <= r_neg_b;
        r_angle <= r_neg_c ? (32'd0 - w_r) : w_r;
    end

    assign o_valid = r_v[3];
    assign o_angle = r_angle;

endmodule

`default_nettype wire

@@ rtl/gcd_sincos.sv @@
// ----------------------------------------------------------------------------
// gcd_sincos: pipelined rotation CORDIC
// Quadrant fold, one stage per iteration, and a sign fix stage; Q2.30 outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_sincos (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic [31:0]                       i_angle,
    output logic                                   o_valid,
    output logic signed [gcd_pkg::CW-1:0]          o_cos,
    output logic signed [gcd_pkg::CW-1:0]          o_sin
);

    localparam int N = gcd_pkg::ITERS;

    logic signed [gcd_pkg::CW-1:0] r_x [N+1];
    logic signed [gcd_pkg::CW-1:0] r_y [N+1];
    logic signed [gcd_pkg::CW-1:0] r_z [N+1];
    logic [N:0]                    r_flip;
    logic [N:0]                    r_v;
    logic                          r_vout;
    logic signed [gcd_pkg::CW-1:0] r_cos, r_sin;
    logic [31:0]                   w_plus;
    logic                          w_flip;
    logic [31:0]                   w_a;

    // Fold angles in the left half plane by a half turn.
    assign w_plus = i_angle + 32'h4000_0000;
    assign w_flip = w_plus[31];
    assign w_a    = {i_angle[31] ^ w_flip, i_angle[30:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_vout <= 1'b0;
        end else begin
            r_v    <= {r_v[N-1:0], i_valid};
            r_vout <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= gcd_pkg::CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= {{2{w_a[31]}}, w_a};
        r_flip[0] <= w_flip;
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!r_z[i][gcd_pkg::CW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - $signed({2'b00, gcd_pkg::ATAN_TAB[i]});
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + $signed({2'b00, gcd_pkg::ATAN_TAB[i]});
            end
            r_flip[i+1] <= r_flip[i];
        end
    end

    // Undo the fold.
    always_ff @(posedge i_clk) begin
        r_cos <= r_flip[N] ? -r_x[N] : r_x[N];
        r_sin <= r_flip[N] ? -r_y[N] : r_y[N];
    end

    assign o_valid = r_vout;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

`default_nettype wire

@@ rtl/gcd_acos.sv @@
// ----------------------------------------------------------------------------
// gcd_acos: pipelined arccosine
// Square, subtract from one, pipelined integer square root, vectoring CORDIC
// and a clamp to [0, half turn]; output is a binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_acos (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic signed [31:0]    i_c,
    output logic                       o_valid,
    output logic [31:0]                o_angle
);

    localparam int N  = gcd_pkg::ITERS;
    localparam int S  = gcd_pkg::SQRT_STEPS;
    localparam int CW = gcd_pkg::CW;

    logic                    r_v1, r_v2, r_vi, r_vout;
    logic [S-1:0]            r_vs;
    logic [N-1:0]            r_vc;
    logic signed [31:0]      r_c1;
    logic [60:0]             r_csq;
    logic [60:0]             r_sn [S+1];
    logic [61:0]             r_sr [S+1];
    logic signed [31:0]      r_sc [S+1];
    logic signed [CW-1:0]    r_x [N+1];
    logic signed [CW-1:0]    r_y [N+1];
    logic signed [CW-1:0]    r_z [N+1];
    logic [31:0]             r_angle;
    logic signed [63:0]      w_sq;
    logic signed [CW-1:0]    w_root;
    logic signed [CW-1:0]    w_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_vs   <= '0;
            r_vi   <= 1'b0;
            r_vc   <= '0;
            r_vout <= 1'b0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_vs   <= {r_vs[S-2:0], r_v2};
            r_vi   <= r_vs[S-1];
            r_vc   <= {r_vc[N-2:0], r_vi};
            r_vout <= r_vc[N-1];
        end
    end

    // One minus c squared, in Q60.
    assign w_sq = 64'(i_c) * 64'(i_c);

    always_ff @(posedge i_clk) begin
        r_c1     <= i_c;
        r_csq    <= w_sq[60:0];
        r_sn[0]  <= (61'd1 << 60) - r_csq;
        r_sr[0]  <= '0;
        r_sc[0]  <= r_c1;
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 0; j < S; j++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
        logic [61:0] w_t;
        assign w_t = r_sr[j] + BIT;
        always_ff @(posedge i_clk) begin
            if ({1'b0, r_sn[j]} >= w_t) begin
                r_sn[j+1] <= r_sn[j] - w_t[60:0];
                r_sr[j+1] <= (r_sr[j] >> 1) + BIT;
            end else begin
                r_sn[j+1] <= r_sn[j];
                r_sr[j+1] <= r_sr[j] >> 1;
            end
            r_sc[j+1] <= r_sc[j];
        end
    end

    // Start vector: (c, root) or, for negative c, rotated by a quarter turn.
    assign w_root = $signed({3'b000, r_sr[S][30:0]});
    assign w_c    = CW'(r_sc[S]);

    always_ff @(posedge i_clk) begin
        if (w_c[CW-1]) begin
            r_x[0] <= w_root;
            r_y[0] <= -w_c;
            r_z[0] <= CW'(34'sd1073741824);
        end else begin
            r_x[0] <= w_c;
            r_y[0] <= w_root;
            r_z[0] <= '0;
        end
    end

    // Vectoring micro-rotations drive y toward zero.
    for (genvar i = 0; i < N; i++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!r_y[i][CW-1] && (r_y[i] != '0)) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + $signed({2'b00, gcd_pkg::ATAN_TAB[i]});
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - $signed({2'b00, gcd_pkg::ATAN_TAB[i]});
            end
        end
    end

    // Clamp to [0, half turn].
    always_ff @(posedge i_clk) begin
        if (r_z[N][CW-1]) begin
            r_angle <= '0;
        end else if (r_z[N] > $signed(34'sh0_8000_0000)) begin
            r_angle <= 32'h8000_0000;
        end else begin
            r_angle <= r_z[N][31:0];
        end
    end

    assign o_valid = r_vout;
    assign o_angle = r_angle;

endmodule

`default_nettype wire
